// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `ASSERT_AT(lbl, clk, rst_n, !(cond))
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: hw/rtl/tppd_pkg.sv
// ----------------------------------------------------------------------------
// Tape pulse period decoder package
// Widths, codes and interface types shared by the decoder modules.
// ----------------------------------------------------------------------------
package tppd_pkg;

    localparam int unsigned DEN_W   = 32;
    localparam int unsigned TICK_W  = 21;
    localparam int unsigned ODD_W   = TICK_W + 1;
    localparam int unsigned HALF_W  = 19;
    localparam int unsigned NUM_W   = ODD_W + HALF_W;
    localparam int unsigned CNT_W   = $clog2(NUM_W + 1);
    localparam int unsigned PAUSE_W = 24;

    localparam logic [HALF_W-1:0] HALF_MICROS = HALF_W'(500000);

    localparam logic [1:0] PAUSE_LEN = 2'd3;

    localparam logic [1:0] REG_TICK_FREQ  = 2'd0;
    localparam logic [1:0] REG_FORMAT_VER = 2'd1;
    localparam logic [1:0] REG_DATA_LEN   = 2'd2;

    localparam logic [DEN_W-1:0] TICK_FREQ_RST = DEN_W'(123156);

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ZERO_V0 = 2'd1,
        STATUS_OVERRUN = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// File: hw/rtl/tppd_div.sv
// ----------------------------------------------------------------------------
// Tape pulse period divider
// Restoring divider that produces one quotient bit per cycle, saturated.
// ----------------------------------------------------------------------------
module tppd_div
    import tppd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_ctl         i_ctl,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_sts         o_sts,
    output logic [DEN_W-1:0] o_quotient
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = (|r_quo[NUM_W-1:DEN_W]) ? '1 : r_quo[DEN_W-1:0];

endmodule

// File: hw/rtl/tape_pulse_period_decoder.sv
// ----------------------------------------------------------------------------
// Tape pulse period decoder
// A period result is loaded after its request passes the multiply, load,
// divider and emit states; the next request is taken once back in idle.
// Status-only results go straight to emit, other bytes stay in idle; output stalls hold emit.
// Synchronous active-low reset restores the default registers and clears state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tape_pulse_period_decoder
    import tppd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tuser,  // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] period_us
    output logic [1:0]  m_axis_tuser   // [1:0] status
);

    logic [DEN_W-1:0]   r_tick_freq;
    logic               r_format_ver;
    logic [31:0]        r_data_len;

    t_state             r_state;
    t_state             n_state;

    logic [31:0]        r_byte_count;
    logic [1:0]         r_pause_left;
    logic [PAUSE_W-1:0] r_pause_acc;
    logic [TICK_W-1:0]  r_ticks;
    logic [NUM_W-1:0]   r_num;
    logic [31:0]        r_res_period;
    t_status            r_res_status;

    logic               r_out_valid;
    logic [31:0]        r_out_period;
    t_status            r_out_status;

    logic               accept;
    logic               overrun;
    logic               out_load;
    logic [PAUSE_W-1:0] n_pause_acc;
    t_div_ctl           div_ctl;
    t_div_sts           div_sts;
    logic [DEN_W-1:0]   quotient;

    assign accept      = s_axis_tvalid && s_axis_tready;
    assign overrun     = r_byte_count >= r_data_len;
    assign n_pause_acc = {s_axis_tdata, r_pause_acc[PAUSE_W-1:8]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_freq  <= TICK_FREQ_RST;
            r_format_ver <= 1'b1;
            r_data_len   <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TICK_FREQ:  r_tick_freq  <= i_cfg_data;
                REG_FORMAT_VER: r_format_ver <= i_cfg_data[0];
                REG_DATA_LEN:   r_data_len   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && !s_axis_tuser) begin
                    if (overrun) begin
                        n_state = ST_EMIT;
                    end else if (r_pause_left != 2'd0) begin
                        if (r_pause_left == 2'd1) begin
                            n_state = ST_MUL;
                        end
                    end else if (s_axis_tdata != 8'd0) begin
                        n_state = ST_MUL;
                    end else if (!r_format_ver) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_MUL:  n_state = ST_LOAD;
            ST_LOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (div_sts.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = r_state == ST_IDLE;
        div_ctl.start = r_state == ST_LOAD;
        out_load      = (r_state == ST_EMIT) && (!r_out_valid || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_byte_count <= '0;
            r_pause_left <= '0;
            r_pause_acc  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                if (s_axis_tuser) begin
                    r_byte_count <= '0;
                    r_pause_left <= '0;
                    r_pause_acc  <= '0;
                end else if (!overrun) begin
                    r_byte_count <= r_byte_count + 32'd1;
                    if (r_pause_left != 2'd0) begin
                        r_pause_acc  <= n_pause_acc;
                        r_pause_left <= r_pause_left - 2'd1;
                    end else if (s_axis_tdata == 8'd0 && r_format_ver) begin
                        r_pause_left <= PAUSE_LEN;
                        r_pause_acc  <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res_period <= '0;
            if (overrun) begin
                r_res_status <= STATUS_OVERRUN;
            end else begin
                r_res_status <= STATUS_ZERO_V0;
            end
            if (r_pause_left != 2'd0) begin
                r_ticks <= n_pause_acc[PAUSE_W-1:PAUSE_W-TICK_W];
            end else begin
                r_ticks <= TICK_W'(s_axis_tdata);
            end
        end
        if (r_state == ST_MUL) begin
            r_num <= NUM_W'({r_ticks, 1'b1}) * NUM_W'(HALF_MICROS);
        end
        if (r_state == ST_DIV && div_sts.done) begin
            r_res_period <= quotient;
            r_res_status <= STATUS_OK;
        end
        if (out_load) begin
            r_out_period <= r_res_period;
            r_out_status <= r_res_status;
        end
    end

    tppd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_num      (r_num),
        .i_den      (r_tick_freq),
        .o_sts      (div_sts),
        .o_quotient (quotient)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_period;
    assign m_axis_tuser  = r_out_status;

    `ASSERT_AT(a_busy_in_div, i_clk, i_rst_n, div_sts.busy |-> r_state == ST_DIV)
    `ASSERT_AT(a_done_to_emit, i_clk, i_rst_n, (r_state == ST_DIV && div_sts.done) |=> r_state == ST_EMIT)
    `ASSERT_AT(a_load_shows, i_clk, i_rst_n, out_load |=> m_axis_tvalid)
    `ASSERT_NEVER(a_no_start_busy, i_clk, i_rst_n, div_ctl.start && div_sts.busy)

endmodule
